### hw/rtl/cobs_frame_encoder_core_macros.svh
// assertion macros for the cobs frame encoder core
`ifndef COBS_FRAME_ENCODER_CORE_MACROS_SVH
`define COBS_FRAME_ENCODER_CORE_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define CFE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cfe assertion failed");

// next-cycle implication
`define CFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cfe assertion failed");

`else

`define CFE_ASSERT_IMPL(label, clk, rst, ante, cons)
`define CFE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### hw/rtl/cfe_pkg.sv
// types and constants shared by the cobs frame encoder core
package cfe_pkg;

   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 4;
   localparam int LANES   = 8;
   localparam int LANE_W  = 3;
   localparam int LEN_W   = 9;
   localparam int ROW_BITS = BYTE_W * LANES;

   localparam logic [BYTE_W-1:0] CODE_ONE  = 8'h01;
   localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SHOW
   } state_type;

   typedef struct packed {
      logic accept;
      logic read;
      logic advance;
   } ctrl_cmd_type;

   typedef struct packed {
      logic will_emit;
      logic last_chunk;
   } ctrl_status_type;

endpackage

### hw/rtl/cfe_req_if.sv
// input channel: one raw byte per transfer
interface cfe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_end;

   modport source (output valid, output data_byte, output frame_end, input ready);
   modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

### hw/rtl/cfe_rsp_if.sv
// result channel: up to eight encoded bytes per transfer
interface cfe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte_0;
   logic [7:0] out_byte_1;
   logic [7:0] out_byte_2;
   logic [7:0] out_byte_3;
   logic [7:0] out_byte_4;
   logic [7:0] out_byte_5;
   logic [7:0] out_byte_6;
   logic [7:0] out_byte_7;
   logic [3:0] byte_count;
   logic       run_last;
   logic       frame_last;

   modport source (
      output valid, output out_byte_0, output out_byte_1, output out_byte_2,
      output out_byte_3, output out_byte_4, output out_byte_5, output out_byte_6,
      output out_byte_7, output byte_count, output run_last, output frame_last,
      input ready
   );
   modport sink (
      input valid, input out_byte_0, input out_byte_1, input out_byte_2,
      input out_byte_3, input out_byte_4, input out_byte_5, input out_byte_6,
      input out_byte_7, input byte_count, input run_last, input frame_last,
      output ready
   );
endinterface

### hw/rtl/cfe_ctrl.sv
// controller: accepts bytes and sequences the block drain
module cfe_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  cfe_pkg::ctrl_status_type status,
   output cfe_pkg::ctrl_cmd_type    cmd
);
   import cfe_pkg::*;

`include "cobs_frame_encoder_core_macros.svh"

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.will_emit) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            if (rsp_ready) begin
               state_in = status.last_chunk ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd.accept  = 1'b0;
      cmd.read    = 1'b0;
      cmd.advance = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_READ: begin
            cmd.read = 1'b1;
         end
         ST_SHOW: begin
            rsp_valid   = 1'b1;
            cmd.advance = rsp_ready && !status.last_chunk;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   `CFE_ASSERT_IMPL(a_no_overlap, clock, reset, rsp_valid, !req_ready)
   `CFE_ASSERT_NEXT(a_emit_starts_read, clock, reset, cmd.accept && status.will_emit, state_ff == ST_READ)
   `CFE_ASSERT_NEXT(a_more_chunks, clock, reset, rsp_valid && rsp_ready && !status.last_chunk, state_ff == ST_READ)

endmodule

### hw/rtl/cfe_datapath.sv
// datapath: run code, block store and result byte assembly
module cfe_datapath #(
   parameter int BLOCK_BYTES = 254
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cfe_pkg::ctrl_cmd_type         cmd,
   output cfe_pkg::ctrl_status_type      status,
   input  logic [7:0]                    data_byte,
   input  logic                          frame_end,
   output logic [cfe_pkg::BYTE_W-1:0]    out_bytes [cfe_pkg::LANES],
   output logic [cfe_pkg::COUNT_W-1:0]   byte_count,
   output logic                          run_last,
   output logic                          frame_last
);
   import cfe_pkg::*;

`include "cobs_frame_encoder_core_macros.svh"

   localparam int ROWS  = BLOCK_BYTES / LANES + 1;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

   // row r lane j holds stream position 8r+j; position 0 is the code byte
   logic [ROW_BITS-1:0] store_mem [ROWS];
   logic [ROW_BITS-1:0] rd_data_ff;

   logic [BYTE_W-1:0] run_code_ff;
   logic [BYTE_W-1:0] run_code_in;
   logic [BYTE_W-1:0] code_ff;
   logic [BYTE_W-1:0] code_in;
   logic [LEN_W-1:0]  len_ff;
   logic [LEN_W-1:0]  len_in;
   logic              extra_ff;
   logic              extra_in;
   logic              end_ff;
   logic              end_in;
   logic [ROW_W-1:0]  chunk_ff;
   logic [ROW_W-1:0]  chunk_in;

   logic              byte_zero;
   logic              block_full;
   logic [ROW_W-1:0]  wr_row;
   logic [LANE_W-1:0] wr_lane;
   logic [LEN_W-1:0]  chunk_base;
   logic [LEN_W-1:0]  lane_pos [LANES];
   logic [LEN_W-1:0]  remain;

   assign byte_zero  = (data_byte == BYTE_ZERO);
   assign block_full = (run_code_ff == BYTE_W'(BLOCK_BYTES));
   assign wr_row     = ROW_W'(run_code_ff >> LANE_W);
   assign wr_lane    = run_code_ff[LANE_W-1:0];

   assign status.will_emit = byte_zero || block_full || frame_end;

   always_comb begin
      run_code_in = run_code_ff;
      code_in     = code_ff;
      len_in      = len_ff;
      extra_in    = extra_ff;
      end_in      = end_ff;
      chunk_in    = chunk_ff;
      if (cmd.accept) begin
         code_in  = byte_zero ? run_code_ff : run_code_ff + 8'd1;
         extra_in = byte_zero && frame_end;
         len_in   = LEN_W'(code_in) + LEN_W'(extra_in);
         end_in   = frame_end;
         chunk_in = '0;
         if (status.will_emit) begin
            run_code_in = CODE_ONE;
         end else begin
            run_code_in = run_code_ff + 8'd1;
         end
      end else if (cmd.advance) begin
         chunk_in = chunk_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_code_ff <= CODE_ONE;
      end else begin
         run_code_ff <= run_code_in;
      end
      code_ff  <= code_in;
      len_ff   <= len_in;
      extra_ff <= extra_in;
      end_ff   <= end_in;
      chunk_ff <= chunk_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && !byte_zero) begin
         store_mem[wr_row][wr_lane*BYTE_W +: BYTE_W] <= data_byte;
      end
      if (cmd.read) begin
         rd_data_ff <= store_mem[chunk_ff];
      end
   end

   assign chunk_base        = LEN_W'(chunk_ff) << LANE_W;
   assign remain            = len_ff - chunk_base;
   assign status.last_chunk = ((len_ff - 1'b1) >> LANE_W) == LEN_W'(chunk_ff);

   always_comb begin
      for (int j = 0; j < LANES; j++) begin
         lane_pos[j] = chunk_base + LEN_W'(j);
         if (lane_pos[j] == '0) begin
            out_bytes[j] = code_ff;
         end else if (lane_pos[j] < LEN_W'(code_ff)) begin
            out_bytes[j] = rd_data_ff[j*BYTE_W +: BYTE_W];
         end else if (extra_ff && lane_pos[j] == LEN_W'(code_ff)) begin
            // zero byte at frame end: trailing one-byte block
            out_bytes[j] = CODE_ONE;
         end else begin
            out_bytes[j] = BYTE_ZERO;
         end
      end
   end

   assign byte_count = status.last_chunk ? COUNT_W'(remain) : COUNT_W'(LANES);
   assign run_last   = status.last_chunk;
   assign frame_last = status.last_chunk && end_ff;

   `CFE_ASSERT_IMPL(a_run_bound, clock, reset, 1'b1, run_code_ff <= BYTE_W'(BLOCK_BYTES))
   `CFE_ASSERT_NEXT(a_code_restart, clock, reset, cmd.accept && status.will_emit, run_code_ff == CODE_ONE)
   `CFE_ASSERT_NEXT(a_chunk_restart, clock, reset, cmd.accept, chunk_ff == '0)

endmodule

### hw/rtl/cobs_frame_encoder_core.sv
// a byte that closes no block is taken and gives no result
// an emitting byte: an accept, then per result a store row read and a show
// results per byte: ceil(n/8) for n encoded bytes; the single store read port sets the pace
// no byte taken while results pend; a result held in show waits until it is taken
// reset: synchronous, active high; run code back to 1, controller idle
// block store contents are not cleared, so no clearing pass follows reset
module cobs_frame_encoder_core #(
   parameter int BLOCK_BYTES = 254
) (
   input logic      clock,
   input logic      reset,
   cfe_req_if.sink  req_chan,
   cfe_rsp_if.source rsp_chan
);
   import cfe_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;
   logic [BYTE_W-1:0] out_bytes [LANES];

   cfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   cfe_datapath #(
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .data_byte  (req_chan.data_byte),
      .frame_end  (req_chan.frame_end),
      .out_bytes  (out_bytes),
      .byte_count (rsp_chan.byte_count),
      .run_last   (rsp_chan.run_last),
      .frame_last (rsp_chan.frame_last)
   );

   assign rsp_chan.out_byte_0 = out_bytes[0];
   assign rsp_chan.out_byte_1 = out_bytes[1];
   assign rsp_chan.out_byte_2 = out_bytes[2];
   assign rsp_chan.out_byte_3 = out_bytes[3];
   assign rsp_chan.out_byte_4 = out_bytes[4];
   assign rsp_chan.out_byte_5 = out_bytes[5];
   assign rsp_chan.out_byte_6 = out_bytes[6];
   assign rsp_chan.out_byte_7 = out_bytes[7];

endmodule

### test/cobs_frame_encoder_core_tb.sv
// testbench for the cobs frame encoder core: table-driven and random frames against a predictor
`timescale 1ns / 100ps

module cobs_frame_encoder_core_tb;
   import cfe_pkg::*;

   localparam int BLOCK_BYTES   = 254;
   localparam int SEQ_MAX       = BLOCK_BYTES + 2;
   localparam int SEND_ITEMS    = 400;
   localparam int TAIL_CYCLES   = 80;
   localparam int DIRECTED_ROWS = 25;

   typedef struct packed {
      logic [LANES-1:0][BYTE_W-1:0] lanes;
      logic [COUNT_W-1:0]           count;
      logic                         run_last;
      logic                         frame_last;
   } encoded_chunk_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              frame_end;
      logic              typed;
      encoded_chunk_type reply;
   } stim_row_type;

   typedef enum int {
      FRAME_SHORT,
      FRAME_FULL_END
   } frame_kind_type;

   localparam encoded_chunk_type NO_CHUNK = '0;

   // typed replies only where the encoding is obvious from an idle encoder
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{8'h00, 1'b1, 1'b1, '{64'h0101, 4'd2, 1'b1, 1'b1}},
      '{8'hff, 1'b1, 1'b1, '{64'hff02, 4'd2, 1'b1, 1'b1}},
      '{8'h00, 1'b0, 1'b1, '{64'h0001, 4'd1, 1'b1, 1'b0}},
      '{8'h00, 1'b1, 1'b1, '{64'h0101, 4'd2, 1'b1, 1'b1}},
      '{8'h01, 1'b1, 1'b1, '{64'h0102, 4'd2, 1'b1, 1'b1}},
      '{8'h80, 1'b0, 1'b0, NO_CHUNK},
      '{8'h7f, 1'b0, 1'b0, NO_CHUNK},
      '{8'h55, 1'b0, 1'b0, NO_CHUNK},
      '{8'haa, 1'b0, 1'b0, NO_CHUNK},
      '{8'h01, 1'b0, 1'b0, NO_CHUNK},
      '{8'hfe, 1'b0, 1'b0, NO_CHUNK},
      '{8'h02, 1'b0, 1'b0, NO_CHUNK},
      '{8'h40, 1'b0, 1'b0, NO_CHUNK},
      '{8'h00, 1'b0, 1'b0, NO_CHUNK},
      '{8'h11, 1'b0, 1'b0, NO_CHUNK},
      '{8'h22, 1'b1, 1'b0, NO_CHUNK},
      '{8'h33, 1'b0, 1'b0, NO_CHUNK},
      '{8'h00, 1'b1, 1'b0, NO_CHUNK},
      '{8'h01, 1'b0, 1'b0, NO_CHUNK},
      '{8'h02, 1'b0, 1'b0, NO_CHUNK},
      '{8'h04, 1'b0, 1'b0, NO_CHUNK},
      '{8'h08, 1'b0, 1'b0, NO_CHUNK},
      '{8'h10, 1'b0, 1'b0, NO_CHUNK},
      '{8'h20, 1'b0, 1'b0, NO_CHUNK},
      '{8'hff, 1'b1, 1'b0, NO_CHUNK}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   cfe_req_if req_chan ();
   cfe_rsp_if rsp_chan ();

   cobs_frame_encoder_core #(
      .BLOCK_BYTES(BLOCK_BYTES)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [BYTE_W-1:0] held_run [BLOCK_BYTES];
   int                next_code = CODE_ONE;
   logic [BYTE_W-1:0] encoded_seq [SEQ_MAX];
   int                encoded_len;

   encoded_chunk_type pending_chunks [$];
   int                mismatch_count = 0;
   int                sent_items = 0;
   bit                send_quiet = 1'b0;
   bit                drain_quiet = 1'b0;

   task automatic draw_gap(inout bit quiet, output int gap);
      if ($urandom_range(0, 31) == 0)
         quiet = !quiet;
      gap = quiet ? 0 : $urandom_range(0, 19);
   endtask

   task automatic append_open_block();
      int held;
      held = next_code - 1;
      if (held > BLOCK_BYTES)
         held = BLOCK_BYTES;
      encoded_seq[encoded_len] = next_code[BYTE_W-1:0];
      encoded_len++;
      for (int i = 0; i < held; i++) begin
         encoded_seq[encoded_len] = held_run[i];
         encoded_len++;
      end
   endtask

   task automatic encode_byte(input logic [BYTE_W-1:0] b, input logic e,
                              input bit typed, input encoded_chunk_type typed_chunk);
      bit                full_close;
      int                chunks;
      int                base;
      int                cnt;
      encoded_chunk_type c;
      encoded_len = 0;
      full_close  = 1'b0;
      if (b != BYTE_ZERO && next_code - 1 < BLOCK_BYTES) begin
         held_run[next_code-1] = b;
         next_code++;
      end
      if (b == BYTE_ZERO || next_code >= BLOCK_BYTES + 1) begin
         append_open_block();
         full_close = (b != BYTE_ZERO);
         next_code  = CODE_ONE;
      end
      if (e) begin
         // a block closed full on the last byte gets no trailing code
         if (!full_close)
            append_open_block();
         next_code = CODE_ONE;
      end
      if (typed) begin
         pending_chunks.push_back(typed_chunk);
      end else begin
         chunks = (encoded_len + LANES - 1) / LANES;
         for (int k = 0; k < chunks; k++) begin
            base = k * LANES;
            cnt  = encoded_len - base;
            if (cnt > LANES)
               cnt = LANES;
            c = '0;
            for (int j = 0; j < cnt; j++)
               c.lanes[j] = encoded_seq[base + j];
            c.count      = cnt[COUNT_W-1:0];
            c.run_last   = (k == chunks - 1);
            c.frame_last = (k == chunks - 1) && e;
            pending_chunks.push_back(c);
         end
      end
   endtask

   // entered just after a rising edge; returns just after the transfer edge
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic e,
                            input bit typed, input encoded_chunk_type typed_chunk);
      int gap;
      draw_gap(send_quiet, gap);
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.data_byte <= b;
      req_chan.frame_end <= e;
      do @(posedge clock); while (!req_chan.ready);
      sent_items++;
      encode_byte(b, e, typed, typed_chunk);
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_chunks.size() != 0) @(negedge clock);
   endtask

   function automatic logic [BYTE_W-1:0] random_frame_byte();
      int pick;
      pick = $urandom_range(0, 15);
      if (pick < 4)
         return BYTE_ZERO;
      else if (pick == 4)
         return 8'hff;
      else
         return BYTE_W'($urandom_range(1, 255));
   endfunction

   task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                              input logic [BYTE_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic check_result();
      encoded_chunk_type got;
      encoded_chunk_type want;
      got.lanes[0]   = rsp_chan.out_byte_0;
      got.lanes[1]   = rsp_chan.out_byte_1;
      got.lanes[2]   = rsp_chan.out_byte_2;
      got.lanes[3]   = rsp_chan.out_byte_3;
      got.lanes[4]   = rsp_chan.out_byte_4;
      got.lanes[5]   = rsp_chan.out_byte_5;
      got.lanes[6]   = rsp_chan.out_byte_6;
      got.lanes[7]   = rsp_chan.out_byte_7;
      got.count      = rsp_chan.byte_count;
      got.run_last   = rsp_chan.run_last;
      got.frame_last = rsp_chan.frame_last;
      if (pending_chunks.size() == 0) begin
         $error("unexpected result: out_byte_0 %0h, byte_count %0d",
                got.lanes[0], got.count);
         mismatch_count++;
      end else begin
         want = pending_chunks.pop_front();
         for (int j = 0; j < LANES; j++)
            check_field($sformatf("out_byte_%0d", j), want.lanes[j], got.lanes[j]);
         check_field("byte_count", want.count, got.count);
         check_field("run_last", want.run_last, got.run_last);
         check_field("frame_last", want.frame_last, got.frame_last);
      end
   endtask

   // result side
   initial begin
      int gap;
      rsp_chan.ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         draw_gap(drain_quiet, gap);
         @(negedge clock);
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         check_result();
      end
   end

   initial begin
      #20_000_000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      logic [BYTE_W-1:0] frame_bytes [$];
      frame_kind_type    kind;
      int                frame_index;
      int                len;
      req_chan.valid     = 1'b0;
      req_chan.data_byte = '0;
      req_chan.frame_end = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_byte(directed_rows[i].data_byte, directed_rows[i].frame_end,
                   directed_rows[i].typed, directed_rows[i].reply);
      hold_until_drained();
      @(posedge clock);

      frame_index = 0;
      while (sent_items < SEND_ITEMS) begin
         // one long run that closes a full block exactly at frame end
         if (frame_index == 3)
            kind = FRAME_FULL_END;
         else
            kind = FRAME_SHORT;
         frame_bytes.delete();
         case (kind)
            FRAME_FULL_END: begin
               repeat (BLOCK_BYTES)
                  frame_bytes.push_back(BYTE_W'($urandom_range(1, 255)));
            end
            default: begin
               len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60)
                                                 : $urandom_range(1, 12);
               repeat (len) frame_bytes.push_back(random_frame_byte());
            end
         endcase
         for (int i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1, 1'b0, NO_CHUNK);
         if ($urandom_range(0, 9) == 0) begin
            hold_until_drained();
            @(posedge clock);
         end
         frame_index++;
      end

      hold_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
